@@ rtl/core/xas_adpcm_group_decoder_top_assert.svh @@
// Assertion macros shared by the XAS group decoder checkers.
`ifndef XAS_ADPCM_GROUP_DECODER_TOP_ASSERT_SVH
`define XAS_ADPCM_GROUP_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define XAS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define XAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/xas_pkg.sv @@
// Shared constants, types and functions of the XAS group decoder.
package xas_pkg;

  localparam int DATA_W        = 8;
  localparam int SAMPLE_W      = 24;
  localparam int COEF_W        = 8;
  localparam int PROD_W        = COEF_W + SAMPLE_W;
  localparam int ACC_W         = 36;
  localparam int FRACTION_BITS = 8;
  localparam int GROUP_BYTES   = 76;
  localparam int HEADER_BYTES  = 16;
  localparam int POS_W         = 7;
  localparam int BLK_W         = 2;
  localparam int IDX_W         = 5;
  localparam int SHIFT_MAX     = 12;
  localparam int SH_W          = 5;
  localparam int PRED_SHIFT    = 6;
  localparam int RES_BASE      = 12 + FRACTION_BITS;

  localparam logic signed [ACC_W-1:0] SAT_MAX = 36'sd8388607;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -36'sd8388608;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_MUL_A,
    ST_MUL_B,
    ST_EMIT
  } state_t;

  // Byte role within a 4-byte sub-block header
  typedef enum logic [1:0] {
    HDR_FILTER = 2'd0,
    HDR_SEED0  = 2'd1,
    HDR_SHIFT  = 2'd2,
    HDR_SEED1  = 2'd3
  } hdr_phase_t;

  // Sequencer commands to the datapath
  typedef struct packed {
    logic [BLK_W-1:0]  blk;
    logic [DATA_W-1:0] data;
    logic [3:0]        code;
    logic              hdr_filter_we;
    logic              hdr_shift_we;
    logic              seed_push;
    logic              dec_push;
    logic              mac_load;
    logic              mac_add;
    logic [IDX_W-1:0]  idx;
    logic              last;
  } ctrl_t;

  // First predictor tap, in 64ths
  function automatic logic signed [COEF_W-1:0] coef_first(input logic [1:0] f);
    logic signed [COEF_W-1:0] c;
    case (f)
      2'd0:    c = 8'sd0;
      2'd1:    c = 8'sd60;
      2'd2:    c = 8'sd115;
      default: c = 8'sd98;
    endcase
    return c;
  endfunction

  // Second predictor tap, in 64ths
  function automatic logic signed [COEF_W-1:0] coef_second(input logic [1:0] f);
    logic signed [COEF_W-1:0] c;
    case (f)
      2'd0:    c = 8'sd0;
      2'd1:    c = 8'sd0;
      2'd2:    c = -8'sd52;
      default: c = -8'sd55;
    endcase
    return c;
  endfunction

  // Clamp to signed 24 bits
  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    if (v > SAT_MAX) t = SAT_MAX;
    else if (v < SAT_MIN) t = SAT_MIN;
    else t = v;
    return t[SAMPLE_W-1:0];
  endfunction

endpackage

@@ rtl/core/xas_if.sv @@
// Request channel interfaces: encoded bytes in, decoded samples out.
interface xas_in_if;
  logic                           valid;
  logic                           ready;
  logic [xas_pkg::DATA_W-1:0]     data_byte;
  logic                           group_start;

  modport source (output valid, output data_byte, output group_start, input ready);
  modport sink   (input valid, input data_byte, input group_start, output ready);
endinterface

interface xas_out_if;
  logic                               valid;
  logic                               ready;
  logic [xas_pkg::BLK_W-1:0]          sub_block;
  logic [xas_pkg::IDX_W-1:0]          sample_index;
  logic signed [xas_pkg::SAMPLE_W-1:0] sample_value;
  logic                               group_last;

  modport source (output valid, output sub_block, output sample_index,
                  output sample_value, output group_last, input ready);
  modport sink   (input valid, input sub_block, input sample_index,
                  input sample_value, input group_last, output ready);
endinterface

@@ rtl/core/xas_mac.sv @@
// Shared multiply-accumulate unit for the two predictor taps.
module xas_mac (
  input  logic                                clk,
  input  logic                                load,
  input  logic                                add,
  input  logic signed [xas_pkg::COEF_W-1:0]   coef,
  input  logic signed [xas_pkg::SAMPLE_W-1:0] sample,
  output logic signed [xas_pkg::ACC_W-1:0]    acc
);

  logic signed [xas_pkg::PROD_W-1:0] prod;
  logic signed [xas_pkg::ACC_W-1:0]  prod_ext;
  logic signed [xas_pkg::ACC_W-1:0]  acc_r;
  logic signed [xas_pkg::ACC_W-1:0]  acc_nxt;

  // 8 x 24 signed product, sign-extended to accumulator width
  assign prod     = xas_pkg::PROD_W'(coef) * xas_pkg::PROD_W'(sample);
  assign prod_ext = {{(xas_pkg::ACC_W-xas_pkg::PROD_W){prod[xas_pkg::PROD_W-1]}}, prod};

  always_comb begin
    acc_nxt = acc_r;
    if (load) acc_nxt = prod_ext;
    else if (add) acc_nxt = acc_r + prod_ext;
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

@@ rtl/core/xas_hist.sv @@
// Per sub-block header state, sample history and result arithmetic.
module xas_hist (
  input  logic                                clk,
  input  logic                                rst_n,
  input  xas_pkg::ctrl_t                      ctl,
  input  logic signed [xas_pkg::ACC_W-1:0]    acc,
  output logic signed [xas_pkg::COEF_W-1:0]   mac_coef,
  output logic signed [xas_pkg::SAMPLE_W-1:0] mac_sample,
  output logic signed [xas_pkg::SAMPLE_W-1:0] value
);

  logic [1:0]                          filter_r [4];
  logic [3:0]                          shift_r  [4];
  logic signed [xas_pkg::SAMPLE_W-1:0] prev_r   [4];
  logic signed [xas_pkg::SAMPLE_W-1:0] older_r  [4];
  logic [3:0]                          pend_r;

  logic [1:0]                          cur_filter;
  logic [xas_pkg::SH_W-1:0]            res_shift;
  logic signed [xas_pkg::ACC_W-1:0]    code_ext;
  logic signed [xas_pkg::ACC_W-1:0]    resid;
  logic signed [xas_pkg::ACC_W-1:0]    pred;
  logic signed [15:0]                  seed16;
  logic signed [xas_pkg::ACC_W-1:0]    seed_full;
  logic [3:0]                          shift_clamped;
  logic                                push;

  assign cur_filter = filter_r[ctl.blk];

  // Operand select for the shared multiplier: first tap, then second tap
  assign mac_coef   = ctl.mac_add ? xas_pkg::coef_second(cur_filter)
                                  : xas_pkg::coef_first(cur_filter);
  assign mac_sample = ctl.mac_add ? older_r[ctl.blk] : prev_r[ctl.blk];

  // Residual: code scaled by 2^(12+frac-shift)
  assign res_shift = xas_pkg::SH_W'(xas_pkg::RES_BASE) - xas_pkg::SH_W'(shift_r[ctl.blk]);
  assign code_ext  = {{(xas_pkg::ACC_W-4){ctl.code[3]}}, ctl.code};
  assign resid     = code_ext <<< res_shift;
  // Floored prediction
  assign pred      = acc >>> xas_pkg::PRED_SHIFT;

  // Seed from header high byte and held low nibble
  assign seed16    = {ctl.data, pend_r, 4'b0000};
  assign seed_full = {{(xas_pkg::ACC_W-16){seed16[15]}}, seed16} <<< xas_pkg::FRACTION_BITS;

  assign value = ctl.seed_push ? xas_pkg::sat24(seed_full)
                               : xas_pkg::sat24(resid + pred);

  assign shift_clamped = (ctl.data[3:0] > 4'(xas_pkg::SHIFT_MAX)) ? 4'(xas_pkg::SHIFT_MAX)
                                                                   : ctl.data[3:0];
  assign push = ctl.seed_push | ctl.dec_push;

  // Header fields and history updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      for (int b = 0; b < 4; b++) begin
        filter_r[b] <= '0;
        shift_r[b]  <= '0;
        prev_r[b]   <= '0;
        older_r[b]  <= '0;
      end
    end else begin
      if (ctl.hdr_filter_we) begin
        filter_r[ctl.blk] <= ctl.data[1:0];
        pend_r            <= ctl.data[7:4];
      end
      if (ctl.hdr_shift_we) begin
        shift_r[ctl.blk] <= shift_clamped;
        pend_r           <= ctl.data[7:4];
      end
      if (push) begin
        older_r[ctl.blk] <= prev_r[ctl.blk];
        prev_r[ctl.blk]  <= value;
      end
    end
  end

endmodule

@@ rtl/core/xas_ctrl.sv @@
// Sequencer: byte position tracking and step control of the shared unit.
module xas_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [xas_pkg::DATA_W-1:0]  in_data_byte,
  input  logic                        in_group_start,
  input  logic                        out_free,
  output logic                        in_ready,
  output xas_pkg::ctrl_t              ctl
);

  xas_pkg::state_t              state_r, state_nxt;
  xas_pkg::hdr_phase_t          phase_r;
  logic [xas_pkg::POS_W-1:0]    posn_r;
  logic [xas_pkg::DATA_W-1:0]   byte_r;
  logic [xas_pkg::BLK_W-1:0]    blk_r;
  logic [xas_pkg::IDX_W-1:0]    idx_r;
  logic                         last_r;
  logic                         head_r;
  logic                         nib_r;

  logic                         accept;
  logic [xas_pkg::POS_W-1:0]    start_pos;
  logic [xas_pkg::POS_W-1:0]    data_off;
  logic                         is_head;

  assign accept    = in_valid && in_ready;
  assign start_pos = in_group_start ? '0 : posn_r;
  assign is_head   = start_pos < xas_pkg::POS_W'(xas_pkg::HEADER_BYTES);
  assign data_off  = start_pos - xas_pkg::POS_W'(xas_pkg::HEADER_BYTES);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      xas_pkg::ST_IDLE:
        if (accept) state_nxt = is_head ? xas_pkg::ST_HEAD : xas_pkg::ST_MUL_A;
      xas_pkg::ST_HEAD:
        if (phase_r == xas_pkg::HDR_FILTER || phase_r == xas_pkg::HDR_SHIFT || out_free)
          state_nxt = xas_pkg::ST_IDLE;
      xas_pkg::ST_MUL_A:
        state_nxt = xas_pkg::ST_MUL_B;
      xas_pkg::ST_MUL_B:
        state_nxt = xas_pkg::ST_EMIT;
      xas_pkg::ST_EMIT:
        if (out_free) state_nxt = nib_r ? xas_pkg::ST_IDLE : xas_pkg::ST_MUL_A;
      default:
        state_nxt = xas_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready          = (state_r == xas_pkg::ST_IDLE);
    ctl.blk           = blk_r;
    ctl.data          = byte_r;
    ctl.code          = nib_r ? byte_r[3:0] : byte_r[7:4];
    ctl.hdr_filter_we = (state_r == xas_pkg::ST_HEAD) && (phase_r == xas_pkg::HDR_FILTER);
    ctl.hdr_shift_we  = (state_r == xas_pkg::ST_HEAD) && (phase_r == xas_pkg::HDR_SHIFT);
    ctl.seed_push     = (state_r == xas_pkg::ST_HEAD) && out_free &&
                        (phase_r == xas_pkg::HDR_SEED0 || phase_r == xas_pkg::HDR_SEED1);
    ctl.dec_push      = (state_r == xas_pkg::ST_EMIT) && out_free;
    ctl.mac_load      = (state_r == xas_pkg::ST_MUL_A);
    ctl.mac_add       = (state_r == xas_pkg::ST_MUL_B);
    ctl.idx           = idx_r | {{(xas_pkg::IDX_W-1){1'b0}}, nib_r};
    ctl.last          = last_r && nib_r && !head_r;
  end

  // State and item registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= xas_pkg::ST_IDLE;
      posn_r  <= '0;
      nib_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        posn_r <= (start_pos == xas_pkg::POS_W'(xas_pkg::GROUP_BYTES - 1)) ? '0
                                                                            : start_pos + 1'b1;
        nib_r  <= 1'b0;
      end else if (ctl.dec_push) begin
        nib_r  <= 1'b1;
      end
    end
  end

  // Item payload captured at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r  <= in_data_byte;
      head_r  <= is_head;
      phase_r <= xas_pkg::hdr_phase_t'(start_pos[1:0]);
      last_r  <= (start_pos == xas_pkg::POS_W'(xas_pkg::GROUP_BYTES - 1));
      if (is_head) begin
        blk_r <= start_pos[3:2];
        idx_r <= {{(xas_pkg::IDX_W-1){1'b0}}, start_pos[1]};
      end else begin
        blk_r <= data_off[1:0];
        idx_r <= {data_off[5:2], 1'b0} + xas_pkg::IDX_W'(2);
      end
    end
  end

endmodule

@@ rtl/core/xas_adpcm_group_decoder_top.sv @@
// Top level of the XAS ADPCM group decoder, one channel.
//
// Usage: feed the 76 bytes of an encoded channel group on in_ch, one byte
// per request; group_start = 1 forces the byte to position 0 of a new group,
// otherwise positions run 0..75 and wrap. Decoded samples leave on out_ch
// tagged with sub-block, sample index and a last flag on the group's final
// sample. Header filter/shift bytes give no sample, seed bytes give one,
// data bytes give two (high nibble first).
// Sequence: a header byte passes through HEAD back to IDLE; each nibble of
// a data byte takes two multiply-accumulate steps (MUL_A, MUL_B) on the
// single shared 8x24 multiplier, then the sum and saturation (EMIT).
// A sample is visible on out_ch the cycle after it is produced.
// Reset (rst_n low, synchronous) clears the byte position, the sub-block
// headers and the sample history, and empties the output register.
// Stall: a sample sits in the output register until taken; the sequencer
// waits before writing the next one, and in_ch.ready stays low until the
// current byte is fully delivered into that register.
module xas_adpcm_group_decoder_top (
  input  logic      clk,
  input  logic      rst_n,
  xas_in_if.sink    in_ch,
  xas_out_if.source out_ch
);

  xas_pkg::ctrl_t                      ctl;
  logic                                out_free;
  logic signed [xas_pkg::COEF_W-1:0]   mac_coef;
  logic signed [xas_pkg::SAMPLE_W-1:0] mac_sample;
  logic signed [xas_pkg::ACC_W-1:0]    acc;
  logic signed [xas_pkg::SAMPLE_W-1:0] value;
  logic                                push;

  logic                                out_vld_r;
  logic [xas_pkg::BLK_W-1:0]           out_blk_r;
  logic [xas_pkg::IDX_W-1:0]           out_idx_r;
  logic signed [xas_pkg::SAMPLE_W-1:0] out_val_r;
  logic                                out_last_r;

  assign out_free = !out_vld_r || out_ch.ready;
  assign push     = ctl.seed_push | ctl.dec_push;

  xas_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_data_byte   (in_ch.data_byte),
    .in_group_start (in_ch.group_start),
    .out_free       (out_free),
    .in_ready       (in_ch.ready),
    .ctl            (ctl)
  );

  xas_hist u_hist (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .acc        (acc),
    .mac_coef   (mac_coef),
    .mac_sample (mac_sample),
    .value      (value)
  );

  xas_mac u_mac (
    .clk    (clk),
    .load   (ctl.mac_load),
    .add    (ctl.mac_add),
    .coef   (mac_coef),
    .sample (mac_sample),
    .acc    (acc)
  );

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (push) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (push) begin
      out_blk_r  <= ctl.blk;
      out_idx_r  <= ctl.idx;
      out_val_r  <= value;
      out_last_r <= ctl.last;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.sub_block    = out_blk_r;
  assign out_ch.sample_index = out_idx_r;
  assign out_ch.sample_value = out_val_r;
  assign out_ch.group_last   = out_last_r;

endmodule

@@ rtl/core/xas_checker.sv @@
// Port-level checker for the XAS group decoder, bound to the top level.
`include "xas_adpcm_group_decoder_top_assert.svh"

module xas_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [xas_pkg::BLK_W-1:0]           out_sub_block,
  input logic [xas_pkg::IDX_W-1:0]           out_sample_index,
  input logic signed [xas_pkg::SAMPLE_W-1:0] out_sample_value,
  input logic                                out_group_last
);

  // A stalled sample holds its value
  `XAS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sample_value), "stalled sample changed")

  // Each request is worked on before the next one is taken
  `XAS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready stayed high after accept")

  // The group end flag marks only the last sample of sub-block 3
  `XAS_ASSERT_NOW(a_last_pos, out_valid && out_group_last, out_sub_block == 2'd3 && out_sample_index == 5'd31, "group_last on wrong sample")

  // Odd data samples follow their even partner of the same sub-block
  `XAS_ASSERT_NEXT(a_pair_order, out_valid && out_ready && out_sample_index != 5'd31 && out_sample_index[0] == 1'b0 && out_sample_index != 5'd0, !out_valid || out_sub_block == $past(out_sub_block), "nibble pair split across sub-blocks")

endmodule

bind xas_adpcm_group_decoder_top xas_checker u_xas_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_sub_block    (out_ch.sub_block),
  .out_sample_index (out_ch.sample_index),
  .out_sample_value (out_ch.sample_value),
  .out_group_last   (out_ch.group_last)
);

@@ tb/sv/xas_adpcm_group_decoder_top_test.sv @@
// Self-checking testbench for the XAS ADPCM group decoder: byte stream in, samples checked.
`timescale 1ns / 100ps

module xas_adpcm_group_decoder_top_test;

  localparam int RANDOM_BYTES = 1400;
  localparam int STUCK_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int DIRECTED_N   = 25;

  // One decoded sample as it leaves the block
  typedef struct packed {
    logic [xas_pkg::BLK_W-1:0]           blk;
    logic [xas_pkg::IDX_W-1:0]           idx;
    logic signed [xas_pkg::SAMPLE_W-1:0] val;
    logic                                last;
  } sample_t;

  // Directed stimulus row; known_val overrides the first sample when has_known
  typedef struct {
    logic [xas_pkg::DATA_W-1:0] data;
    bit                         start;
    bit                         has_known;
    int                         known_val;
  } byte_row_t;

  logic clk = 1'b0;
  logic rst_n;

  xas_in_if  in_ch();
  xas_out_if out_ch();

  xas_adpcm_group_decoder_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Decoder model state
  logic [xas_pkg::POS_W-1:0]           grp_pos;
  logic [3:0]                          seed_low;
  logic [1:0]                          filt_sel [4];
  logic [3:0]                          shift_amt [4];
  logic signed [xas_pkg::SAMPLE_W-1:0] hist_prev [4];
  logic signed [xas_pkg::SAMPLE_W-1:0] hist_older [4];

  // Predictor taps in 64ths
  longint tap_prev [4]  = '{0, 60, 115, 98};
  longint tap_older [4] = '{0, 0, -52, -55};

  sample_t exp_samples [$];
  int      error_count = 0;
  int      stuck_cycles = 0;
  bit      calm = 1'b0;
  int      out_stall = 0;

  byte_row_t dir_rows [DIRECTED_N] = '{
    '{8'hF7, 1'b1, 1'b0, 0},          // filter nibble 7 masks to 3
    '{8'h7F, 1'b0, 1'b1, 8384512},    // largest seed
    '{8'h0D, 1'b0, 1'b0, 0},          // shift 13 clamps to 12
    '{8'h80, 1'b0, 1'b1, -8388608},   // most negative seed
    '{8'h01, 1'b0, 1'b0, 0},
    '{8'h00, 1'b0, 1'b1, 0},
    '{8'hF0, 1'b0, 1'b0, 0},          // shift 0
    '{8'hFF, 1'b0, 1'b1, -4096},
    '{8'h06, 1'b0, 1'b0, 0},          // filter nibble 6 masks to 2
    '{8'h40, 1'b0, 1'b1, 4194304},
    '{8'h0F, 1'b0, 1'b0, 0},          // shift 15 clamps to 12
    '{8'hC0, 1'b0, 1'b1, -4194304},
    '{8'h00, 1'b0, 1'b0, 0},
    '{8'h12, 1'b0, 1'b1, 1179648},
    '{8'hAE, 1'b0, 1'b0, 0},          // shift 14 clamps to 12
    '{8'h34, 1'b0, 1'b1, 3448832},
    '{8'h08, 1'b0, 1'b0, 0},
    '{8'h78, 1'b0, 1'b0, 0},
    '{8'h00, 1'b0, 1'b1, -8388608},   // prediction saturates low
    '{8'h87, 1'b0, 1'b0, 0},
    '{8'hFF, 1'b0, 1'b0, 0},
    '{8'h80, 1'b0, 1'b0, 0},
    '{8'h02, 1'b1, 1'b0, 0},          // restart mid group, history kept
    '{8'h55, 1'b0, 1'b0, 0},
    '{8'h3C, 1'b0, 1'b0, 0}
  };

  function automatic logic signed [xas_pkg::SAMPLE_W-1:0] clamp_sample(input longint v);
    longint t;
    if (v > xas_pkg::SAT_MAX) t = xas_pkg::SAT_MAX;
    else if (v < xas_pkg::SAT_MIN) t = xas_pkg::SAT_MIN;
    else t = v;
    return t[xas_pkg::SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [xas_pkg::SAMPLE_W-1:0] seed_from(input logic [3:0] lo,
                                                                    input logic [7:0] hi);
    longint s;
    s = longint'($signed(hi)) * 256 + longint'({lo, 4'b0000});
    return clamp_sample(s <<< xas_pkg::FRACTION_BITS);
  endfunction

  // One nibble through the two-tap predictor; updates the history
  function automatic logic signed [xas_pkg::SAMPLE_W-1:0] decode_nibble(
      input int b, input logic [3:0] code);
    longint resid;
    longint acc;
    logic signed [xas_pkg::SAMPLE_W-1:0] v;
    resid = longint'($signed(code)) <<< (xas_pkg::RES_BASE - shift_amt[b]);
    acc = tap_prev[filt_sel[b]] * longint'(hist_prev[b])
        + tap_older[filt_sel[b]] * longint'(hist_older[b]);
    v = clamp_sample(resid + (acc >>> xas_pkg::PRED_SHIFT));
    hist_older[b] = hist_prev[b];
    hist_prev[b] = v;
    return v;
  endfunction

  // Expected samples for one accepted byte
  function automatic void decode_byte(input logic [7:0] d, input bit st,
                                      output sample_t s0, output sample_t s1,
                                      output int n);
    int b;
    int dpos;
    logic [4:0] idx;
    logic signed [xas_pkg::SAMPLE_W-1:0] v;
    n = 0;
    s0 = '0;
    s1 = '0;
    if (st) grp_pos = '0;
    if (grp_pos >= xas_pkg::GROUP_BYTES) grp_pos = '0;
    if (grp_pos < xas_pkg::HEADER_BYTES) begin
      b = int'(grp_pos[3:2]);
      case (xas_pkg::hdr_phase_t'(grp_pos[1:0]))
        xas_pkg::HDR_FILTER: begin
          filt_sel[b] = d[1:0];
          seed_low = d[7:4];
        end
        xas_pkg::HDR_SHIFT: begin
          shift_amt[b] = (d[3:0] > xas_pkg::SHIFT_MAX) ? 4'(xas_pkg::SHIFT_MAX) : d[3:0];
          seed_low = d[7:4];
        end
        default: begin
          v = seed_from(seed_low, d);
          hist_older[b] = hist_prev[b];
          hist_prev[b] = v;
          s0 = '{blk: 2'(b),
                 idx: (grp_pos[1:0] == xas_pkg::HDR_SEED0) ? 5'd0 : 5'd1,
                 val: v, last: 1'b0};
          n = 1;
        end
      endcase
    end else begin
      dpos = int'(grp_pos) - xas_pkg::HEADER_BYTES;
      b = dpos % 4;
      idx = 5'(2 + 2 * (dpos / 4));
      s0 = '{blk: 2'(b), idx: idx, val: decode_nibble(b, d[7:4]), last: 1'b0};
      s1 = '{blk: 2'(b), idx: idx + 5'd1, val: decode_nibble(b, d[3:0]),
             last: (int'(grp_pos) == xas_pkg::GROUP_BYTES - 1)};
      n = 2;
    end
    grp_pos = (int'(grp_pos) + 1 >= xas_pkg::GROUP_BYTES) ? '0 : grp_pos + 1'b1;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Send one byte request; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] d, input bit st,
                           input bit has_known, input int known_val);
    sample_t s0;
    sample_t s1;
    int n;
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.data_byte = d;
    in_ch.group_start = st;
    in_ch.valid = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    decode_byte(d, st, s0, s1, n);
    if (has_known) s0.val = known_val[xas_pkg::SAMPLE_W-1:0];
    if (n > 0) exp_samples.push_back(s0);
    if (n > 1) exp_samples.push_back(s1);
    @(negedge clk);
  endtask

  // Result side back-pressure
  always @(negedge clk) begin
    if (out_stall != 0) begin
      out_ch.ready = 1'b0;
      out_stall--;
    end else begin
      out_ch.ready = 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) out_stall = idle_len();
    end
  end

  // Result checker
  always @(posedge clk) begin
    sample_t got;
    sample_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.sub_block, out_ch.sample_index, out_ch.sample_value,
              out_ch.group_last};
      if (exp_samples.size() == 0) begin
        error_count++;
        $display("%0t: unexpected sample blk=%0d idx=%0d val=%0d last=%0b",
                 $time, got.blk, got.idx, got.val, got.last);
      end else begin
        want = exp_samples.pop_front();
        if (got.blk !== want.blk) begin
          error_count++;
          $display("%0t: sub_block expected %0d actual %0d", $time, want.blk, got.blk);
        end
        if (got.idx !== want.idx) begin
          error_count++;
          $display("%0t: sample_index expected %0d actual %0d", $time, want.idx, got.idx);
        end
        if (got.val !== want.val) begin
          error_count++;
          $display("%0t: sample_value expected %0d actual %0d (blk %0d idx %0d)",
                   $time, want.val, got.val, want.blk, want.idx);
        end
        if (got.last !== want.last) begin
          error_count++;
          $display("%0t: group_last expected %0b actual %0b", $time, want.last, got.last);
        end
      end
    end
  end

  // Watchdog on cycles with no request moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles", $time, STUCK_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    int sent;
    int chunk;
    bit first_start;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.group_start = 1'b0;
    grp_pos = '0;
    seed_low = '0;
    for (int b = 0; b < 4; b++) begin
      filt_sel[b] = '0;
      shift_amt[b] = '0;
      hist_prev[b] = '0;
      hist_older[b] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table
    foreach (dir_rows[i])
      send_byte(dir_rows[i].data, dir_rows[i].start, dir_rows[i].has_known,
                dir_rows[i].known_val);

    // Random groups: mostly whole groups, some cut short or restarted
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      calm = ($urandom_range(0, 7) == 0);
      chunk = ($urandom_range(0, 4) == 0) ? $urandom_range(1, xas_pkg::GROUP_BYTES - 1)
                                          : xas_pkg::GROUP_BYTES;
      first_start = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < chunk; k++) begin
        send_byte(8'($urandom_range(0, 255)), (k == 0) ? first_start : 1'b0, 1'b0, 0);
        sent++;
      end
    end
    in_ch.valid = 1'b0;
    calm = 1'b1;

    // Drain
    while (exp_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (exp_samples.size() != 0) begin
      error_count++;
      $display("%0t: %0d expected samples never arrived", $time, exp_samples.size());
    end
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
